### rtl/megaco_token_matcher_unit_assert.svh
// Assertion macros for the token matcher RTL.
`ifndef MEGACO_TOKEN_MATCHER_UNIT_ASSERT_SVH
`define MEGACO_TOKEN_MATCHER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is held.
`define MTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is held.
`define MTM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTM_ASSERT(lbl, prop, msg)
`define MTM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/mtm_pkg.sv
// Types, byte constants and character classes of the token matcher.
package mtm_pkg;

    typedef enum logic [3:0] {
        RULE_OPT_WS  = 4'd0,
        RULE_SEP     = 4'd1,
        RULE_EQUAL   = 4'd2,
        RULE_COMMA   = 4'd3,
        RULE_SLASH   = 4'd4,
        RULE_LBRACE  = 4'd5,
        RULE_RBRACE  = 4'd6,
        RULE_OCTET   = 4'd7,
        RULE_NAME    = 4'd8,
        RULE_U16     = 4'd9,
        RULE_U32     = 4'd10,
        RULE_QUOTED  = 4'd11,
        RULE_VALUE   = 4'd12,
        RULE_ADDRESS = 4'd13
    } rule_t;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_MATCH = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    // Control part of the matcher state.
    typedef struct packed {
        logic       busy;
        rule_t      rule;
        logic [1:0] phase;
        logic       sep_seen;
    } ctrl_t;

    // One result as it leaves the step logic.
    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [15:0] length;
    } result_t;

    localparam logic [7:0] CH_HTAB   = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    localparam logic [3:0] DIGITS_U16 = 4'd5;
    localparam logic [3:0] DIGITS_U32 = 4'd10;

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_HTAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic comment_text_char(input logic [7:0] c);
        return c == CH_HTAB || (c >= 8'h20 && c <= 8'h7e);
    endfunction

    function automatic logic is_octet(input logic [7:0] c);
        return (c >= 8'h01 && c <= 8'h5b) || (c >= 8'h5d && c <= 8'h7c) || c >= 8'h7e;
    endfunction

    function automatic logic is_safe(input logic [7:0] c);
        return c == 8'h21 || (c >= 8'h24 && c <= 8'h2b) || (c >= 8'h2d && c <= 8'h39)
            || (c >= 8'h3f && c <= 8'h5a) || c == 8'h5c || (c >= 8'h5e && c <= 8'h7a)
            || c == 8'h7c || c == 8'h7e;
    endfunction

    function automatic logic is_quoted_body(input logic [7:0] c);
        return c == CH_HTAB || c == CH_LF || c == CH_CR || c == CH_SPACE || c == 8'h21
            || (c >= 8'h23 && c <= 8'h7e) || c >= CH_HIGH;
    endfunction

    function automatic logic [7:0] delim_of(input rule_t r);
        logic [7:0] d;
        case (r)
            RULE_EQUAL:  d = CH_EQUAL;
            RULE_COMMA:  d = CH_COMMA;
            RULE_SLASH:  d = CH_SLASH;
            RULE_LBRACE: d = CH_LBRACE;
            default:     d = CH_RBRACE;
        endcase
        return d;
    endfunction

endpackage

### rtl/mtm_step.sv
// Single-byte step of the token matcher: next state and result for one source byte.
module mtm_step #(
    parameter int LENGTH_BITS = 16,
    parameter int NAME_LIMIT  = 64
) (
    input  mtm_pkg::ctrl_t          cur,
    input  logic [LENGTH_BITS-1:0]  cur_committed,
    input  logic [LENGTH_BITS-1:0]  cur_pending,
    input  logic                    start,
    input  logic [3:0]              mode,
    input  logic [7:0]              data,
    input  logic                    at_end,
    output mtm_pkg::ctrl_t          nxt,
    output logic [LENGTH_BITS-1:0]  nxt_committed,
    output logic [LENGTH_BITS-1:0]  nxt_pending,
    output mtm_pkg::result_t        res
);
    import mtm_pkg::*;

    localparam int SUM_W = LENGTH_BITS + 2;
    localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] CNT_TWO = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] NAME_MAX = LENGTH_BITS'(NAME_LIMIT);

    typedef enum logic [1:0] {WS_MORE, WS_HERE, WS_EARLIER, WS_OVF} ws_code_t;

    typedef struct packed {
        ws_code_t               code;
        logic                   sub;
        logic [LENGTH_BITS-1:0] com;
        logic [LENGTH_BITS-1:0] pen;
    } ws_ret_t;

    typedef struct packed {
        logic    done;
        status_t status;
        logic    inc;
    } qstep_t;

    // Whitespace scan; sub is low between items and high inside a comment.
    function automatic ws_ret_t ws_feed(input logic sub, input logic [7:0] c,
                                        input logic fin,
                                        input logic [LENGTH_BITS-1:0] com,
                                        input logic [LENGTH_BITS-1:0] pen,
                                        input logic fits);
        ws_ret_t r;
        r.code = WS_HERE;
        r.sub  = sub;
        r.com  = com;
        r.pen  = pen;
        if (!sub) begin
            if (fin) begin
                r.code = WS_EARLIER;
            end else if (is_ws(c)) begin
                r.code = fits ? WS_MORE : WS_OVF;
                r.com  = com + CNT_ONE;
            end else if (c == CH_SEMI) begin
                r.code = fits ? WS_MORE : WS_OVF;
                r.pen  = pen + CNT_ONE;
                r.sub  = 1'b1;
            end
        end else begin
            if (fin) begin
                r.code = WS_EARLIER;
                r.com  = com + pen;
                r.pen  = '0;
            end else if (comment_text_char(c)) begin
                r.code = fits ? WS_MORE : WS_OVF;
                r.pen  = pen + CNT_ONE;
            end else if (c == CH_LF || c == CH_CR) begin
                r.code = fits ? WS_MORE : WS_OVF;
                r.com  = com + pen + CNT_ONE;
                r.pen  = '0;
                r.sub  = 1'b0;
            end else begin
                r.code = WS_EARLIER;
                r.pen  = '0;
            end
        end
        return r;
    endfunction

    // Body of a quoted string after its opening quote.
    function automatic qstep_t quoted_step(input logic [7:0] c, input logic fin,
                                           input logic fits);
        qstep_t q;
        q.done   = 1'b0;
        q.status = ST_NONE;
        q.inc    = 1'b0;
        if (fin) begin
            q.done = 1'b1;
        end else if (c == CH_QUOTE) begin
            q.done   = 1'b1;
            q.status = fits ? ST_MATCH : ST_OVF;
            q.inc    = fits;
        end else if (is_quoted_body(c)) begin
            q.done   = !fits;
            q.status = ST_OVF;
            q.inc    = fits;
        end else begin
            q.done = 1'b1;
        end
        return q;
    endfunction

    ctrl_t                  eff;
    logic [LENGTH_BITS-1:0] eff_com;
    logic [LENGTH_BITS-1:0] eff_pen;
    logic                   active;
    logic [SUM_W-1:0]       sum1;
    logic [SUM_W-1:0]       sum2;
    logic                   fits1;
    logic                   fits2;
    logic [LENGTH_BITS-1:0] com_inc;
    ws_ret_t                ws_r;
    qstep_t                 qs;
    logic                   done;
    status_t                st;
    logic [3:0]             digit_limit;

    // A start-marked byte opens a fresh attempt before the byte is scanned.
    always_comb
    begin
        if (start) begin
            eff.busy     = 1'b1;
            eff.rule     = rule_t'(mode);
            eff.phase    = 2'd0;
            eff.sep_seen = 1'b0;
            eff_com      = '0;
            eff_pen      = '0;
        end else begin
            eff     = cur;
            eff_com = cur_committed;
            eff_pen = cur_pending;
        end
    end

    assign active  = start || cur.busy;
    assign sum1    = SUM_W'(eff_com) + SUM_W'(eff_pen) + SUM_W'(1);
    assign sum2    = SUM_W'(eff_com) + SUM_W'(eff_pen) + SUM_W'(2);
    assign fits1   = (sum1[SUM_W-1:LENGTH_BITS] == '0);
    assign fits2   = (sum2[SUM_W-1:LENGTH_BITS] == '0);
    assign com_inc = eff_com + CNT_ONE;
    assign ws_r    = ws_feed(eff.phase[0], data, at_end, eff_com, eff_pen, fits1);
    assign qs      = quoted_step(data, at_end, fits1);
    assign digit_limit = (eff.rule == RULE_U16) ? DIGITS_U16 : DIGITS_U32;

    always_comb
    begin
        nxt           = eff;
        nxt_committed = eff_com;
        nxt_pending   = eff_pen;
        done          = 1'b0;
        st            = ST_NONE;
        case (eff.rule)
            RULE_OPT_WS, RULE_SEP:
            begin
                nxt.phase     = {1'b0, ws_r.sub};
                nxt_committed = ws_r.com;
                nxt_pending   = ws_r.pen;
                if (ws_r.code == WS_OVF) begin
                    done = 1'b1;
                    st   = ST_OVF;
                end else if (ws_r.code != WS_MORE) begin
                    done = 1'b1;
                    if (ws_r.com != '0) begin
                        st = ST_MATCH;
                    end else begin
                        st = (eff.rule == RULE_OPT_WS) ? ST_EMPTY : ST_NONE;
                    end
                end
            end
            RULE_EQUAL, RULE_COMMA, RULE_SLASH, RULE_LBRACE, RULE_RBRACE:
            begin
                nxt_committed = ws_r.com;
                nxt_pending   = ws_r.pen;
                if (!eff.phase[1]) begin
                    // Leading whitespace, then the delimiter itself.
                    nxt.phase = {1'b0, ws_r.sub};
                    if (ws_r.code == WS_OVF) begin
                        done = 1'b1;
                        st   = ST_OVF;
                    end else if (ws_r.code != WS_MORE) begin
                        if (ws_r.code == WS_EARLIER || data != delim_of(eff.rule)) begin
                            done = 1'b1;
                            st   = ST_NONE;
                        end else if (!fits1) begin
                            done = 1'b1;
                            st   = ST_OVF;
                        end else begin
                            nxt_committed = com_inc;
                            nxt.phase     = 2'd2;
                        end
                    end
                end else begin
                    nxt.phase = {1'b1, ws_r.sub};
                    if (ws_r.code == WS_OVF) begin
                        done = 1'b1;
                        st   = ST_OVF;
                    end else if (ws_r.code != WS_MORE) begin
                        done = 1'b1;
                        st   = ST_MATCH;
                    end
                end
            end
            RULE_OCTET:
            begin
                if (eff.phase == 2'd0 && !at_end && is_octet(data)) begin
                    nxt_committed = com_inc;
                    done          = !fits1;
                    st            = ST_OVF;
                end else if (eff.phase == 2'd0 && !at_end && data == CH_BSLASH) begin
                    nxt.phase = 2'd1;
                end else if (eff.phase == 2'd1 && !at_end && data == CH_RBRACE) begin
                    nxt.phase     = 2'd0;
                    nxt_committed = eff_com + CNT_TWO;
                    done          = !fits2;
                    st            = ST_OVF;
                end else begin
                    // A lone backslash ends the string without being consumed.
                    done = 1'b1;
                    st   = (eff_com != '0) ? ST_MATCH : ST_EMPTY;
                end
            end
            RULE_NAME:
            begin
                if (eff.phase == 2'd0 && (at_end || !alpha_char(data))) begin
                    done = 1'b1;
                    st   = ST_NONE;
                end else if (eff.phase != 2'd0
                             && (at_end || !(alpha_char(data) || digit_char(data)
                                             || data == CH_UNDER))) begin
                    done = 1'b1;
                    st   = ST_MATCH;
                end else begin
                    nxt.phase = 2'd1;
                    if (!fits1) begin
                        done = 1'b1;
                        st   = ST_OVF;
                    end else begin
                        nxt_committed = com_inc;
                        done          = (com_inc >= NAME_MAX);
                        st            = ST_MATCH;
                    end
                end
            end
            RULE_U16, RULE_U32:
            begin
                if (!at_end && digit_char(data)) begin
                    if (!fits1) begin
                        done = 1'b1;
                        st   = ST_OVF;
                    end else begin
                        nxt_committed = com_inc;
                        done          = (com_inc >= LENGTH_BITS'(digit_limit));
                        st            = ST_MATCH;
                    end
                end else begin
                    done = 1'b1;
                    st   = (eff_com != '0) ? ST_MATCH : ST_NONE;
                end
            end
            RULE_QUOTED:
            begin
                if (eff.phase == 2'd0) begin
                    if (at_end || data != CH_QUOTE) begin
                        done = 1'b1;
                        st   = ST_NONE;
                    end else begin
                        nxt.phase     = 2'd1;
                        nxt_committed = com_inc;
                        done          = !fits1;
                        st            = ST_OVF;
                    end
                end else begin
                    if (qs.inc) begin
                        nxt_committed = com_inc;
                    end
                    done = qs.done;
                    st   = qs.status;
                end
            end
            RULE_VALUE:
            begin
                if (eff.phase == 2'd0) begin
                    if (!at_end && (data == CH_QUOTE || is_safe(data) || data >= CH_HIGH)) begin
                        nxt.phase     = (data == CH_QUOTE) ? 2'd1 : 2'd2;
                        nxt_committed = com_inc;
                        done          = !fits1;
                        st            = ST_OVF;
                    end else begin
                        done = 1'b1;
                        st   = ST_NONE;
                    end
                end else if (eff.phase == 2'd1) begin
                    if (qs.inc) begin
                        nxt_committed = com_inc;
                    end
                    done = qs.done;
                    st   = qs.status;
                end else if (!at_end && (is_safe(data) || data >= CH_HIGH)) begin
                    nxt_committed = com_inc;
                    done          = !fits1;
                    st            = ST_OVF;
                end else begin
                    done = 1'b1;
                    st   = ST_MATCH;
                end
            end
            RULE_ADDRESS:
            begin
                if (eff.phase == 2'd0) begin
                    if (at_end || data != CH_LBRACK) begin
                        done = 1'b1;
                        st   = ST_NONE;
                    end else begin
                        nxt.phase     = 2'd1;
                        nxt_committed = com_inc;
                        done          = !fits1;
                        st            = ST_OVF;
                    end
                end else if (at_end) begin
                    done = 1'b1;
                    st   = ST_NONE;
                end else if (!fits1) begin
                    done = 1'b1;
                    st   = ST_OVF;
                end else begin
                    nxt_committed = com_inc;
                    if (data == CH_RBRACK) begin
                        done = 1'b1;
                        st   = eff.sep_seen ? ST_MATCH : ST_NONE;
                    end else if (data == CH_COLON || data == CH_DOT) begin
                        nxt.sep_seen = 1'b1;
                    end
                end
            end
            default:
            begin
                done = 1'b1;
                st   = ST_NONE;
            end
        endcase

        if (!active) begin
            nxt           = cur;
            nxt_committed = cur_committed;
            nxt_pending   = cur_pending;
            done          = 1'b0;
        end else begin
            nxt.busy = !done;
        end
    end

    always_comb
    begin
        res.valid  = done;
        res.status = st;
        if (st == ST_NONE || st == ST_OVF) begin
            res.length = '0;
        end else begin
            res.length = 16'(nxt_committed);
        end
    end

endmodule

### rtl/megaco_token_matcher_unit.sv
// Top level of the text-protocol token matcher: input register, state and result register.
//
//  Channel   Direction  Transaction content
//  s_*       in         one source byte: tdata = data, tuser = start_req, mode, at_end
//  m_*       out        one match result: tdata = length, tuser = status
//
// The block takes one source byte per clock while m_* results are taken. A byte accepted on s_* is held in an
// input register; once the result register is free, the combinational step logic scans it against the
// latched rule, updates the rule state and, when the rule is decided, loads the result
// register. A result therefore passes the input register and then the result register before it shows on m_*.
// The sustained rate is one byte per cycle while results are taken, set by the one step unit that must finish
// each byte before the next one reads the rule state.
// Reset clears the input register, the rule state and the result register, so the
// block starts idle. While a result waits with m_tready low, one more byte may be
// accepted into the input register; s_tready then drops until the result is taken.
module megaco_token_matcher_unit #(
    parameter int LENGTH_BITS = 16,
    parameter int NAME_LIMIT  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [5:0]  s_tuser,   // [0] start_req, [4:1] mode, [5] at_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] length
    output logic [1:0]  m_tuser    // [1:0] status
);
    import mtm_pkg::*;

    `include "megaco_token_matcher_unit_assert.svh"

    // Input register: one byte and its side flags.
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_data_reg;
    logic [5:0]             in_user_reg;

    // Rule state carried from byte to byte.
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [LENGTH_BITS-1:0] committed_reg;
    logic [LENGTH_BITS-1:0] committed_next;
    logic [LENGTH_BITS-1:0] pending_reg;
    logic [LENGTH_BITS-1:0] pending_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                out_status_reg;
    logic [15:0]            out_length_reg;

    logic                   in_fire;
    logic                   step_fire;
    logic                   out_free;
    result_t                step_res;

    // The held byte is scanned once the result register can take whatever it yields.
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || step_fire;
    assign in_fire   = s_tvalid && s_tready;

    mtm_step #(
        .LENGTH_BITS (LENGTH_BITS),
        .NAME_LIMIT  (NAME_LIMIT)
    ) u_step (
        .cur           (ctrl_reg),
        .cur_committed (committed_reg),
        .cur_pending   (pending_reg),
        .start         (in_user_reg[0]),
        .mode          (in_user_reg[4:1]),
        .data          (in_data_reg),
        .at_end        (in_user_reg[5]),
        .nxt           (ctrl_next),
        .nxt_committed (committed_next),
        .nxt_pending   (pending_next),
        .res           (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = step_fire && step_res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            committed_reg <= '0;
            pending_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                ctrl_reg      <= ctrl_next;
                committed_reg <= committed_next;
                pending_reg   <= pending_next;
            end
        end
    end

    // Payload registers need no reset; they are qualified by the valid bits above.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (step_fire && step_res.valid) begin
            out_status_reg <= step_res.status;
            out_length_reg <= step_res.length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_length_reg;
    assign m_tuser  = out_status_reg;

    `MTM_ASSERT(a_result_loaded, step_fire && step_res.valid |=> out_valid_reg, "decided rule did not load the result register")
    `MTM_ASSERT(a_busy_rule_known, ctrl_reg.busy |-> ctrl_reg.rule <= RULE_ADDRESS, "open attempt holds an unused rule code")
    `MTM_ASSERT(a_pending_ws_only, pending_reg != '0 |-> ctrl_reg.rule <= RULE_RBRACE, "comment bytes pending outside a whitespace rule")
    `MTM_ASSERT(a_len_zero_no_match, out_valid_reg && (out_status_reg == ST_NONE || out_status_reg == ST_OVF) |-> out_length_reg == '0, "failed match reports a nonzero length")
    `MTM_ASSERT_ALWAYS(a_scan_needs_byte, step_fire |-> in_valid_reg, "step logic fired without a held byte")

endmodule
